// ===== design/quadrature_x4_angle_decoder_core_assert.svh =====
// Assertion macros for the decoder's checker file.
`ifndef QUADRATURE_X4_ANGLE_DECODER_CORE_ASSERT_SVH
`define QUADRATURE_X4_ANGLE_DECODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QAD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/qad_pkg.sv =====
// Types, codes and constants shared by the quadrature decoder modules.
package qad_pkg;

	typedef enum logic [1:0] {
		FN_EDGE = 2'd0,
		FN_ZERO = 2'd1,
		FN_SEED = 2'd2,
		FN_RSVD = 2'd3
	} qad_func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} qad_state_t;

	localparam logic [1:0] REG_CPR    = 2'd0;
	localparam logic [1:0] REG_LINE_A = 2'd1;
	localparam logic [1:0] REG_LINE_B = 2'd2;

	localparam logic [15:0] CPR_RESET    = 16'd1024;
	localparam logic [5:0]  LINE_A_RESET = 6'd0;
	localparam logic [5:0]  LINE_B_RESET = 6'd1;

	localparam logic [1:0] STEP_NONE = 2'b00;
	localparam logic [1:0] STEP_POS  = 2'b01;
	localparam logic [1:0] STEP_NEG  = 2'b11;

	// 36000 / 4: the x4 factor folds into the scale, so the divisor is counts_per_rev.
	localparam logic [13:0] ANGLE_SCALE = 14'd9000;

	localparam logic [47:0] ANGLE_MAX     = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] ANGLE_NEG_MAG = 48'h8000_0000_0000;
	localparam logic [47:0] ANGLE_MIN     = 48'h8000_0000_0000;

	localparam logic signed [31:0] POS32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] POS32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [15:0] cpr;
		logic [5:0]  line_a_id;
		logic [5:0]  line_b_id;
	} qad_cfg_t;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] line_offset;
		logic       rising;
		logic       seed_a_level;
		logic       seed_b_level;
	} qad_item_t;

	typedef struct packed {
		logic accept;
		logic div_load;
		logic div_step;
		logic out_load;
	} qad_cmd_t;

	// Step for an old/new level pair; index is {old A, old B, new A, new B}.
	function automatic logic [1:0] step_of(input logic [3:0] idx);
		logic [1:0] s;
		s = STEP_NONE;
		if (idx inside {4'd2, 4'd4, 4'd11, 4'd13}) begin
			s = STEP_POS;
		end else if (idx inside {4'd1, 4'd7, 4'd8, 4'd14}) begin
			s = STEP_NEG;
		end
		return s;
	endfunction

endpackage

// ===== design/qad_regs.sv =====
// Configuration register file behind the APB-style port.
module qad_regs import qad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output qad_cfg_t    cfg
);

	qad_cfg_t cfg_q;
	logic     wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cpr       <= CPR_RESET;
			cfg_q.line_a_id <= LINE_A_RESET;
			cfg_q.line_b_id <= LINE_B_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_CPR:    cfg_q.cpr       <= pwdata[15:0];
				REG_LINE_A: cfg_q.line_a_id <= pwdata[5:0];
				REG_LINE_B: cfg_q.line_b_id <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CPR:    prdata = {16'd0, cfg_q.cpr};
			REG_LINE_A: prdata = {26'd0, cfg_q.line_a_id};
			REG_LINE_B: prdata = {26'd0, cfg_q.line_b_id};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== design/qad_div.sv =====
// Restoring divider that retires two quotient bits per step.
module qad_div #(
	parameter int QW = 46
) (
	input  logic          clk,
	input  logic          load,
	input  logic          step,
	input  logic [QW-1:0] dividend,
	input  logic [15:0]   divisor,
	output logic [QW-1:0] quotient
);

	logic [15:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [15:0]   rem_d;
	logic [QW-1:0] quo_d;
	logic [16:0]   trial;

	// The quotient register shifts the dividend out at the top and the quotient in below.
	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		trial = 17'd0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_d, quo_d[QW-1]};
			quo_d = {quo_d[QW-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial    = trial - {1'b0, divisor};
				quo_d[0] = 1'b1;
			end
			rem_d = trial[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= 16'd0;
			quo_q <= dividend;
		end else if (step) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign quotient = quo_q;

endmodule

// ===== design/qad_dp.sv =====
// Datapath: levels, position, angle scaling and the result register.
module qad_dp import qad_pkg::*; #(
	parameter int PW = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  qad_cmd_t    cmd,
	input  qad_item_t   item,
	input  qad_cfg_t    cfg,
	output logic [31:0] out_position,
	output logic [47:0] out_angle,
	output logic        out_ambiguous,
	output logic [1:0]  out_step
);

	localparam int DW   = PW + 14;
	localparam int QW   = 2 * ((DW + 1) / 2);
	localparam int CW   = (QW > 48) ? QW : 48;
	localparam int PWX  = (PW > 32) ? PW : 32;

	localparam logic signed [PW-1:0]  POS_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0]  POS_MIN = {1'b1, {(PW-1){1'b0}}};
	localparam logic signed [PWX-1:0] PC_MAX  = PWX'(POS32_MAX);
	localparam logic signed [PWX-1:0] PC_MIN  = PWX'(POS32_MIN);

	logic [1:0]           ab_q;
	logic signed [PW-1:0] pos_q;
	logic [1:0]           step_q;
	logic                 amb_q;
	logic                 neg_q;

	logic [1:0]           lev_d;
	logic signed [PW-1:0] pos_d;
	logic [1:0]           step_d;
	logic                 amb_d;

	logic [PW-1:0]        mag;
	logic [DW-1:0]        prod;
	logic [15:0]          divisor;
	logic [QW-1:0]        quotient;
	logic [CW-1:0]        qz;
	logic [47:0]          angle_d;
	logic signed [PWX-1:0] pos_ext;
	logic [31:0]          pos_rep;

	always_comb begin
		lev_d  = ab_q;
		pos_d  = pos_q;
		step_d = STEP_NONE;
		amb_d  = 1'b0;
		case (item.func)
			FN_EDGE: begin
				if (item.line_offset == cfg.line_a_id) begin
					lev_d[1] = item.rising;
				end else if (item.line_offset == cfg.line_b_id) begin
					lev_d[0] = item.rising;
				end
				step_d = step_of({ab_q, lev_d});
				if (step_d == STEP_POS) begin
					if (pos_q != POS_MAX) begin
						pos_d = pos_q + {{(PW-1){1'b0}}, 1'b1};
					end
				end else if (step_d == STEP_NEG) begin
					if (pos_q != POS_MIN) begin
						pos_d = pos_q - {{(PW-1){1'b0}}, 1'b1};
					end
				end else begin
					amb_d = (lev_d != ab_q);
				end
			end
			FN_ZERO: pos_d = '0;
			FN_SEED: lev_d = {item.seed_a_level, item.seed_b_level};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ab_q  <= 2'b00;
			pos_q <= '0;
		end else if (cmd.accept) begin
			ab_q  <= lev_d;
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			step_q <= step_d;
			amb_q  <= amb_d;
		end
		if (cmd.div_load) begin
			neg_q <= pos_q[PW-1];
		end
	end

	// |position| * 9000 feeds the divider register directly.
	assign mag     = pos_q[PW-1] ? (~pos_q + {{(PW-1){1'b0}}, 1'b1}) : pos_q;
	assign prod    = DW'(mag) * DW'(ANGLE_SCALE);
	assign divisor = (cfg.cpr == 16'd0) ? 16'd1 : cfg.cpr;

	qad_div #(
		.QW(QW)
	) u_div (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (QW'(prod)),
		.divisor  (divisor),
		.quotient (quotient)
	);

	assign qz = CW'(quotient);

	always_comb begin
		if (!neg_q) begin
			angle_d = (qz > CW'(ANGLE_MAX)) ? ANGLE_MAX : qz[47:0];
		end else begin
			angle_d = (qz > CW'(ANGLE_NEG_MAG)) ? ANGLE_MIN : (~qz[47:0] + 48'd1);
		end
	end

	assign pos_ext = PWX'(pos_q);

	always_comb begin
		if (pos_ext > PC_MAX) begin
			pos_rep = POS32_MAX;
		end else if (pos_ext < PC_MIN) begin
			pos_rep = POS32_MIN;
		end else begin
			pos_rep = pos_ext[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_position  <= pos_rep;
			out_angle     <= angle_d;
			out_ambiguous <= amb_q;
			out_step      <= step_q;
		end
	end

endmodule

// ===== design/qad_ctrl.sv =====
// Sequencer: accepts a beat, runs the scaling divide and hands off the result.
module qad_ctrl import qad_pkg::*; #(
	parameter int STEPS = 23
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic     m_tready,
	output logic     s_tready,
	output logic     m_tvalid,
	output qad_cmd_t cmd
);

	localparam int CNTW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(STEPS - 1);

	qad_state_t      state_q;
	qad_state_t      state_d;
	logic [CNTW-1:0] cnt_q;
	logic            m_tvalid_q;
	logic            out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == CNT_LAST) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		s_tready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_MUL:  cmd.div_load = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + {{(CNTW-1){1'b0}}, 1'b1};
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// ===== design/quadrature_x4_angle_decoder_core.sv =====
// Top level of the x4 quadrature decoder with angle output.
// A taken input beat passes the multiply state, the divide state and the done state,
// where the divide runs STEPS = ceil((POSITION_WIDTH+14)/2) divider steps (23 at the default width).
// Only one input beat is worked on at a time; a new one is taken once its result is loaded,
// as the beats share one radix-4 divider that scales position to centidegrees.
// Reset (arst_n low, asynchronous): levels and position clear to zero, registers
// return to their defaults, and no result beat is pending.
module quadrature_x4_angle_decoder_core import qad_pkg::*; #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input beat.
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: line_offset[5:0], rising[6], seed_a_level[7], seed_b_level[8], zero[15:9].
	input  logic [15:0] s_tdata,
	// s_tuser: func[1:0].
	input  logic [1:0]  s_tuser,
	// Result beat.
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: position_count[31:0], angle_centideg[79:32], ambiguous[80],
	// step_dir[82:81], zero[87:83].
	output logic [87:0] m_tdata,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// The angle is |position| * 9000 / counts_per_rev; the dividend is PW+14 bits,
	// rounded up to an even width so the divider retires two bits per step.
	localparam int STEPS = (POSITION_WIDTH + 15) / 2;

	qad_cfg_t    cfg;
	qad_item_t   item;
	qad_cmd_t    cmd;
	logic [31:0] out_position;
	logic [47:0] out_angle;
	logic        out_ambiguous;
	logic [1:0]  out_step;

	assign pready = 1'b1;

	// Unpack the input beat into the decoder's item fields.
	assign item.func         = s_tuser;
	assign item.line_offset  = s_tdata[5:0];
	assign item.rising       = s_tdata[6];
	assign item.seed_a_level = s_tdata[7];
	assign item.seed_b_level = s_tdata[8];

	qad_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The controller takes one beat at a time; the result register lets the next
	// beat enter while the previous result still waits downstream.
	qad_ctrl #(
		.STEPS(STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	qad_dp #(
		.PW(POSITION_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item          (item),
		.cfg           (cfg),
		.out_position  (out_position),
		.out_angle     (out_angle),
		.out_ambiguous (out_ambiguous),
		.out_step      (out_step)
	);

	assign m_tdata = {5'd0, out_step, out_ambiguous, out_angle, out_position};

endmodule

// ===== design/qad_checker.sv =====
// Port-level checker for the quadrature decoder, bound to the top level.
`include "quadrature_x4_angle_decoder_core_assert.svh"

module qad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);

	// One beat is worked on at a time, so input ready drops right after a take.
	`QAD_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "ready after accept")

	`QAD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	`QAD_ASSERT_SAME(a_step_code, m_tvalid, m_tdata[82:81] != 2'b10, "illegal step code")

	// An ambiguous transition never moves the position.
	`QAD_ASSERT_SAME(a_amb_no_step, m_tvalid && m_tdata[80], m_tdata[82:81] == 2'b00, "ambiguous with step")

endmodule

bind quadrature_x4_angle_decoder_core qad_checker u_qad_checker (.*);

// ===== bench/quadrature_x4_angle_decoder_core_tb.sv =====
// Self-checking testbench for the x4 quadrature decoder core with angle output.
`timescale 1ns / 100ps

module quadrature_x4_angle_decoder_core_tb;
	import qad_pkg::*;

	// Long enough for the divider to finish a beat, with some margin.
	localparam int SETTLE_CYCLES = 40;
	// Room for about 620 beats, plus phase drains.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_BEATS   = 100;

	// One expected result beat, laid out as the fields of m_tdata.
	typedef struct {
		logic signed [31:0] position;
		logic [47:0]        angle;
		logic               ambiguous;
		logic [1:0]         step;
	} angle_beat_t;

	// Keeps a private copy of the decoder state and registers, predicts the
	// result of every accepted input beat and checks the result beats in order.
	class angle_tracker;
		logic [15:0]       cpr;
		logic [5:0]        a_id;
		logic [5:0]        b_id;
		logic [1:0]        levels;
		longint            position;
		int                fail_count;
		angle_beat_t       expected_beats[$];

		function new();
			cpr = CPR_RESET;
			a_id = LINE_A_RESET;
			b_id = LINE_B_RESET;
			levels = 2'b00;
			position = 0;
			fail_count = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			fail_count++;
		endtask

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_CPR:    cpr = value[15:0];
				REG_LINE_A: a_id = value[5:0];
				REG_LINE_B: b_id = value[5:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [1:0] idx);
			case (idx)
				REG_CPR:    return {16'd0, cpr};
				REG_LINE_A: return {26'd0, a_id};
				REG_LINE_B: return {26'd0, b_id};
				default:    return 32'd0;
			endcase
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// Quarter-count step for {old A, old B, new A, new B}.
		function int quarter_step(logic [3:0] pair);
			case (pair)
				4'b0010, 4'b0100, 4'b1011, 4'b1101: return 1;
				4'b0001, 4'b0111, 4'b1000, 4'b1110: return -1;
				default: return 0;
			endcase
		endfunction

		// Angle in centidegrees, truncated toward zero and held to 48 bits.
		function logic [47:0] angle_of(longint p);
			longint unsigned mag;
			longint unsigned q;
			longint unsigned lines;
			logic [63:0]     neg_q;
			lines = (cpr == 16'd0) ? 64'd1 : {48'd0, cpr};
			mag = (p < 0) ? -p : p;
			q = (mag * 64'd36000) / (64'd4 * lines);
			if (p >= 0) begin
				return (q > ANGLE_MAX) ? ANGLE_MAX : q[47:0];
			end
			if (q > {16'd0, ANGLE_NEG_MAG}) begin
				q = {16'd0, ANGLE_NEG_MAG};
			end
			neg_q = -q;
			return neg_q[47:0];
		endfunction

		// Notes an accepted input beat and queues the result it must cause.
		function void note_item(qad_item_t it);
			angle_beat_t beat;
			logic [1:0]  next_levels;
			int          delta;
			delta = 0;
			beat.ambiguous = 1'b0;
			case (it.func)
				FN_EDGE: begin
					next_levels = levels;
					// Channel A wins when both ids name the same line.
					if (it.line_offset == a_id) begin
						next_levels[1] = it.rising;
					end else if (it.line_offset == b_id) begin
						next_levels[0] = it.rising;
					end
					delta = quarter_step({levels, next_levels});
					if (delta > 0 && position < longint'(POS32_MAX)) begin
						position++;
					end else if (delta < 0 && position > longint'(POS32_MIN)) begin
						position--;
					end else if (delta == 0 && next_levels != levels) begin
						beat.ambiguous = 1'b1;
					end
					levels = next_levels;
				end
				FN_ZERO: position = 0;
				FN_SEED: levels = {it.seed_a_level, it.seed_b_level};
				default: ;
			endcase
			beat.position = position[31:0];
			beat.angle = angle_of(position);
			beat.step = delta[1:0];
			expected_beats.push_back(beat);
		endfunction

		// Compares one result beat with the oldest expectation.
		task check_beat(logic [87:0] data);
			angle_beat_t want;
			if (expected_beats.size() == 0) begin
				report($sformatf("result beat with nothing expected, data %h", data));
			end else begin
				want = expected_beats.pop_front();
				if (data[31:0] !== want.position) begin
					report($sformatf("position_count %0d, expected %0d",
						$signed(data[31:0]), want.position));
				end
				if (data[79:32] !== want.angle) begin
					report($sformatf("angle_centideg %h, expected %h",
						data[79:32], want.angle));
				end
				if (data[80] !== want.ambiguous) begin
					report($sformatf("ambiguous %b, expected %b", data[80], want.ambiguous));
				end
				if (data[82:81] !== want.step) begin
					report($sformatf("step_dir %b, expected %b", data[82:81], want.step));
				end
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	angle_tracker tracker;
	// When set, both sides stop idling so beats go back to back.
	logic         calm;
	// Direction and remaining length of the current quadrature burst.
	logic         burst_fwd;
	int           burst_left;
	int unsigned  cycle_count;

	quadrature_x4_angle_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic qad_item_t make_item(logic [1:0] func, logic [5:0] line,
			logic rising, logic seed_a, logic seed_b);
		qad_item_t it;
		it.func = func;
		it.line_offset = line;
		it.rising = rising;
		it.seed_a_level = seed_a;
		it.seed_b_level = seed_b;
		return it;
	endfunction

	// Presents one input beat after a random gap and waits for the handshake.
	// The prediction is made at the edge where the beat is taken.
	task automatic send_item(qad_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, it.seed_b_level, it.seed_a_level, it.rising, it.line_offset};
		s_tuser <= it.func;
		do @(posedge clk); while (!s_tready);
		tracker.note_item(it);
	endtask

	// Stops sending and waits until every expected result beat has arrived.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// A register write with a setup and an access phase; the write lands on the access edge.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Reads a register back and compares it with the tracked value.
	task automatic read_reg(logic [1:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== tracker.reg_value(idx)) begin
			tracker.report($sformatf("register %0d reads %h, expected %h",
				idx, prdata, tracker.reg_value(idx)));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reprograms all three registers once the block has gone quiet: every expected
	// result has arrived, and a further settling wait passes before the registers
	// are touched.
	task automatic configure(logic [15:0] cpr, logic [5:0] a_id, logic [5:0] b_id);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_CPR, {16'd0, cpr});
		write_reg(REG_LINE_A, {26'd0, a_id});
		write_reg(REG_LINE_B, {26'd0, b_id});
		read_reg(REG_CPR);
		read_reg(REG_LINE_A);
		read_reg(REG_LINE_B);
	endtask

	// Builds one random input beat. Most beats are clean quadrature steps in
	// bursts of one direction, so the position wanders far from zero; the rest
	// are foreign lines, repeated levels, zero, seed and the unused code.
	function automatic qad_item_t random_item();
		qad_item_t   it;
		int          pick;
		logic        toggle_a;
		logic [1:0]  lv;
		it = 11'($urandom_range(0, 2047));
		lv = tracker.levels;
		pick = $urandom_range(0, 99);
		if (burst_left == 0) begin
			burst_fwd = 1'($urandom_range(0, 1));
			burst_left = $urandom_range(1, 40);
		end
		if (pick < 75) begin
			// Forward order is 00, 10, 11, 01; backward runs it the other way.
			toggle_a = burst_fwd ? (lv[1] == lv[0]) : (lv[1] != lv[0]);
			it.func = FN_EDGE;
			it.line_offset = toggle_a ? tracker.a_id : tracker.b_id;
			it.rising = toggle_a ? !lv[1] : !lv[0];
			burst_left--;
		end else if (pick < 83) begin
			it.func = FN_EDGE;
		end else if (pick < 88) begin
			// Edge that repeats the level a line already has.
			toggle_a = 1'($urandom_range(0, 1));
			it.func = FN_EDGE;
			it.line_offset = toggle_a ? tracker.a_id : tracker.b_id;
			it.rising = toggle_a ? lv[1] : lv[0];
		end else if (pick < 92) begin
			it.func = FN_ZERO;
		end else if (pick < 96) begin
			it.func = FN_SEED;
		end else begin
			it.func = FN_RSVD;
		end
		return it;
	endfunction

	task automatic random_phase();
		for (int n = 0; n < PHASE_BEATS; n++) begin
			if (n % 25 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			// Now and then let the pipeline run completely dry.
			if ($urandom_range(0, 59) == 0) begin
				drain_results();
			end
			send_item(random_item());
		end
		calm = 1'b0;
	endtask

	// Result side: random stalls before each beat, then wait for it.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			tracker.check_beat(m_tdata);
		end
	end

	initial begin : stimulus
		tracker = new();
		calm = 1'b0;
		burst_fwd = 1'b1;
		burst_left = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 16'd0;
		s_tuser <= 2'd0;
		m_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 4'd0;
		pwdata <= 32'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset registers: A is line 0, B is line 1.
		// A full forward cycle, then a full backward cycle.
		send_item(make_item(FN_SEED, 6'd0, 1'b0, 1'b0, 1'b0));
		send_item(make_item(FN_EDGE, 6'd0, 1'b1, 1'b0, 1'b0));
		send_item(make_item(FN_EDGE, 6'd1, 1'b1, 1'b1, 1'b1));
		send_item(make_item(FN_EDGE, 6'd0, 1'b0, 1'b0, 1'b1));
		send_item(make_item(FN_EDGE, 6'd1, 1'b0, 1'b1, 1'b0));
		send_item(make_item(FN_EDGE, 6'd1, 1'b1, 1'b0, 1'b0));
		send_item(make_item(FN_EDGE, 6'd0, 1'b1, 1'b0, 1'b0));
		send_item(make_item(FN_EDGE, 6'd1, 1'b0, 1'b0, 1'b0));
		send_item(make_item(FN_EDGE, 6'd0, 1'b0, 1'b0, 1'b0));
		// Below zero, then an edge that repeats the current level.
		send_item(make_item(FN_EDGE, 6'd1, 1'b1, 1'b0, 1'b0));
		send_item(make_item(FN_EDGE, 6'd1, 1'b1, 1'b0, 1'b0));
		// Edges on lines that are neither A nor B.
		send_item(make_item(FN_EDGE, 6'd63, 1'b1, 1'b1, 1'b1));
		send_item(make_item(FN_EDGE, 6'd42, 1'b0, 1'b0, 1'b1));
		// The unused function code leaves everything as it is.
		send_item(make_item(FN_RSVD, 6'd0, 1'b1, 1'b1, 1'b1));
		send_item(make_item(FN_SEED, 6'd63, 1'b1, 1'b1, 1'b1));
		send_item(make_item(FN_EDGE, 6'd0, 1'b0, 1'b0, 1'b0));
		send_item(make_item(FN_SEED, 6'd21, 1'b0, 1'b1, 1'b0));
		send_item(make_item(FN_EDGE, 6'd1, 1'b1, 1'b0, 1'b0));
		send_item(make_item(FN_ZERO, 6'd63, 1'b1, 1'b1, 1'b1));
		send_item(make_item(FN_SEED, 6'd0, 1'b0, 1'b0, 1'b1));
		send_item(make_item(FN_EDGE, 6'd1, 1'b0, 1'b1, 1'b1));
		send_item(make_item(FN_EDGE, 6'd0, 1'b1, 1'b0, 1'b0));

		// The sender goes straight on into random beats without waiting for the results.
		random_phase();

		// Smallest line count with A and B on the top line numbers.
		configure(16'd1, 6'd63, 6'd62);
		random_phase();

		// Largest line count, with A and B sharing one line: all edges go to A.
		configure(16'hFFFF, 6'd5, 6'd5);
		random_phase();

		// A line count of zero is treated as one.
		configure(16'd0, 6'd17, 6'd40);
		random_phase();

		configure(16'($urandom_range(1, 65535)), 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63)));
		random_phase();

		configure(16'd360, 6'd1, 6'd0);
		random_phase();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
